// ----- sv/sgfpt_pkg.sv -----
// Shared types and constants for the SGF property tokenizer.
package sgfpt_pkg;

  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [KIND_W-1:0] KIND_PROP     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PAIR     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd4;

  localparam logic [CHAR_W-1:0] CH_LPAREN    = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN    = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACKET  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_SEMICOLON = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

  typedef struct packed {
    logic               started;
    logic               in_value;
    logic               escaping;
    logic               finished;
    logic [DEPTH_W-1:0] depth;
  } tok_state_t;

  typedef struct packed {
    logic               emit;
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  char_val;
    logic [DEPTH_W-1:0] depth;
  } tok_result_t;

endpackage

// ----- sv/sgfpt_step.sv -----
// Next-state and result logic for one character of the tokenizer.
module sgfpt_step
  import sgfpt_pkg::*;
#(
  parameter int unsigned DEPTH_LIMIT = 255
) (
  input  tok_state_t        st,
  input  logic [CHAR_W-1:0] byte_val,
  output tok_state_t        st_nxt,
  output tok_result_t       res
);

  localparam logic [DEPTH_W-1:0] LIMIT = DEPTH_W'(DEPTH_LIMIT);

  logic [DEPTH_W-1:0] dec_depth;

  assign dec_depth = (st.depth != '0) ? st.depth - 1'b1 : '0;

  always_comb begin
    st_nxt       = st;
    res.emit     = 1'b0;
    res.kind     = KIND_PROP;
    res.char_val = '0;
    if (st.finished) begin
      st_nxt = st;
    end else if (!st.in_value && byte_val == CH_LPAREN) begin
      st_nxt.started = 1'b1;
      if (st.depth >= LIMIT) begin
        res.emit = 1'b1;
        res.kind = KIND_OVERFLOW;
      end else begin
        st_nxt.depth = st.depth + 1'b1;
      end
    end else if (!st.started) begin
      st_nxt = st;
    end else if (!st.in_value && byte_val == CH_RPAREN) begin
      st_nxt.depth = dec_depth;
      if (dec_depth == '0) begin
        st_nxt.finished = 1'b1;
        res.emit        = 1'b1;
        res.kind        = KIND_END;
      end
    end else if (!st.in_value) begin
      if (byte_val == CH_LBRACKET) begin
        st_nxt.in_value = 1'b1;
      end else if (byte_val != CH_NEWLINE && byte_val != CH_RETURN &&
                   byte_val != CH_SEMICOLON) begin
        res.emit     = 1'b1;
        res.kind     = KIND_PROP;
        res.char_val = byte_val;
      end
    end else if (byte_val == CH_BACKSLASH && !st.escaping) begin
      st_nxt.escaping = 1'b1;
    end else if (byte_val == CH_RBRACKET && !st.escaping) begin
      st_nxt.in_value = 1'b0;
      res.emit        = 1'b1;
      res.kind        = KIND_PAIR;
    end else begin
      st_nxt.escaping = 1'b0;
      res.emit        = 1'b1;
      res.kind        = KIND_VALUE;
      res.char_val    = byte_val;
    end
    res.depth = st_nxt.depth;
  end

endmodule

// ----- sv/sgf_property_tokenizer_unit.sv -----
// Top level of the SGF property tokenizer: input register, step logic, output register.
//
// One character of the game record enters per input word on in_valid/in_ready
// with the character on in_byte. Each character yields zero or one result word on
// out_valid/out_ready carrying out_kind, out_char and out_depth.
// Characters before the first '(' and everything after the closing ')' of the
// outermost level give no result. A '(' at the depth limit (MAX_DEPTH, capped
// at 255) gives a depth-overflow word and leaves the depth unchanged.
// A character taken into the input register has its result in the output register
// once the step advances. Throughput is one character per cycle while out_ready stays
// high: the input register, the tokenizer state and the output register all advance in the same cycle.
// When the receiver stalls, the output register holds its word and the input
// register holds one more character; in_ready drops only when both are full.
// A synchronous active-low reset on rst_n empties both registers and clears the
// state to "not started" at depth zero.
module sgf_property_tokenizer_unit
  import sgfpt_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CHAR_W-1:0]  in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_kind,
  output logic [CHAR_W-1:0]  out_char,
  output logic [DEPTH_W-1:0] out_depth
);

  localparam int unsigned DEPTH_LIMIT = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;

  logic               in_valid_r;
  logic [CHAR_W-1:0]  in_byte_r;
  tok_state_t         st_r;
  tok_state_t         st_nxt;
  tok_result_t        res;
  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic               advance;

  sgfpt_step #(
    .DEPTH_LIMIT(DEPTH_LIMIT)
  ) u_step (
    .st      (st_r),
    .byte_val(in_byte_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= res.emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
    if (advance) begin
      out_kind_r  <= res.kind;
      out_char_r  <= res.char_val;
      out_depth_r <= res.depth;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_char  = out_char_r;
  assign out_depth = out_depth_r;

  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.finished |=> st_r.finished)
    else $error("finished flag cleared without reset");

  a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.depth <= DEPTH_W'(DEPTH_LIMIT))
    else $error("nesting depth above limit");

  a_escape_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.escaping |-> st_r.in_value)
    else $error("escape flag set outside a value");

  a_idle_before_start: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.started |-> (st_r.depth == '0 && !st_r.in_value && !st_r.finished))
    else $error("state changed before the first open bracket");

  a_no_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && st_r.finished) |=> !out_valid_r)
    else $error("result word produced after game end");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r <= KIND_OVERFLOW))
    else $error("result kind out of range");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the SGF property tokenizer: byte stimulus, token prediction, checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sgfpt_pkg::*;

  localparam int unsigned MAX_DEPTH = 255;
  localparam logic [DEPTH_W-1:0] DEPTH_CAP = (MAX_DEPTH < 255) ? DEPTH_W'(MAX_DEPTH) : 8'd255;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  ch;
    logic [DEPTH_W-1:0] depth;
  } token_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CHAR_W-1:0]  in_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [KIND_W-1:0]  out_kind;
  logic [CHAR_W-1:0]  out_char;
  logic [DEPTH_W-1:0] out_depth;

  token_t pending_tokens[$];
  int unsigned mismatches = 0;
  int cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned hold_req = 0;

  logic               tk_started = 1'b0;
  logic               tk_in_value = 1'b0;
  logic               tk_escaping = 1'b0;
  logic               tk_finished = 1'b0;
  logic [DEPTH_W-1:0] tk_depth = '0;

  logic        offering = 1'b0;
  logic        steady = 1'b0;
  int unsigned gap_left = 1;
  int unsigned burst_left = 4;

  sgf_property_tokenizer_unit #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind (out_kind),
    .out_char (out_char),
    .out_depth(out_depth)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void push_token(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch);
    token_t t;
    t.kind = kind;
    t.ch = ch;
    t.depth = tk_depth;
    pending_tokens.push_back(t);
  endfunction

  function automatic void tokenize_byte(input logic [CHAR_W-1:0] b);
    if (tk_finished) return;
    if (!tk_in_value && b == CH_LPAREN) begin
      tk_started = 1'b1;
      if (tk_depth >= DEPTH_CAP) push_token(KIND_OVERFLOW, '0);
      else tk_depth = tk_depth + 1'b1;
      return;
    end
    if (!tk_started) return;
    if (!tk_in_value && b == CH_RPAREN) begin
      if (tk_depth != '0) tk_depth = tk_depth - 1'b1;
      if (tk_depth == '0) begin
        tk_finished = 1'b1;
        push_token(KIND_END, '0);
      end
      return;
    end
    if (!tk_in_value) begin
      if (b == CH_LBRACKET) tk_in_value = 1'b1;
      else if (b != CH_NEWLINE && b != CH_RETURN && b != CH_SEMICOLON) push_token(KIND_PROP, b);
      return;
    end
    if (b == CH_BACKSLASH && !tk_escaping) begin
      tk_escaping = 1'b1;
      return;
    end
    if (b == CH_RBRACKET && !tk_escaping) begin
      tk_in_value = 1'b0;
      push_token(KIND_PAIR, '0);
      return;
    end
    tk_escaping = 1'b0;
    push_token(KIND_VALUE, b);
  endfunction

  task automatic send_byte(input logic [CHAR_W-1:0] b);
    if (!offering && gap_left > 0) repeat (gap_left) @(posedge clk);
    gap_left = 0;
    in_valid <= 1'b1;
    in_byte <= b;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(b);
    items_sent++;
    if (!steady) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
      end
    end
  endtask

  task automatic sender_pause();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    if (gap_left == 0) gap_left = 1;
  endtask

  task automatic wait_drained();
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  // Keeps the outermost level open so that the game does not end early.
  task automatic send_safe(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] c;
    c = b;
    if (!tk_in_value && c == CH_RPAREN && tk_depth <= 8'd1) c = CH_SEMICOLON;
    send_byte(c);
  endtask

  task automatic close_value();
    if (tk_escaping) send_byte(8'h78);
    if (tk_in_value) send_byte(CH_RBRACKET);
  endtask

  function automatic logic [CHAR_W-1:0] letter();
    if ($urandom_range(0, 3) == 0) return CHAR_W'(8'h61 + $urandom_range(0, 25));
    return CHAR_W'(8'h41 + $urandom_range(0, 25));
  endfunction

  task automatic send_property();
    int unsigned n_name;
    int unsigned n_vals;
    int unsigned n_chars;
    n_name = $urandom_range(1, 2);
    repeat (n_name) send_safe(letter());
    n_vals = $urandom_range(1, 3);
    repeat (n_vals) begin
      send_safe(CH_LBRACKET);
      n_chars = $urandom_range(0, 8);
      repeat (n_chars) begin
        if ($urandom_range(0, 7) == 0) begin
          send_safe(CH_BACKSLASH);
          send_safe(CHAR_W'($urandom_range(0, 255)));
        end else begin
          send_safe(CHAR_W'($urandom_range(0, 255)));
        end
      end
      send_safe(CH_RBRACKET);
    end
  endtask

  task automatic test_preamble();
    logic [CHAR_W-1:0] c;
    send_byte(CH_RPAREN);
    send_byte(CH_LBRACKET);
    send_byte(CH_RBRACKET);
    send_byte(CH_BACKSLASH);
    repeat (12) begin
      c = CHAR_W'($urandom_range(0, 255));
      if (c == CH_LPAREN) c = CH_RPAREN;
      send_byte(c);
    end
  endtask

  task automatic test_directed();
    send_byte(CH_LPAREN);
    send_byte(CH_SEMICOLON);
    send_byte(8'h42);
    send_byte(CH_LBRACKET);
    send_byte(8'h61);
    send_byte(CH_LPAREN);
    send_byte(CH_RPAREN);
    send_byte(CH_BACKSLASH);
    send_byte(CH_RBRACKET);
    send_byte(CH_BACKSLASH);
    send_byte(CH_BACKSLASH);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_RBRACKET);
    send_byte(CH_NEWLINE);
    send_byte(CH_RETURN);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_LPAREN);
    send_byte(CH_SEMICOLON);
    send_byte(8'h57);
    send_byte(CH_LBRACKET);
    send_byte(CH_RBRACKET);
    send_byte(CH_RPAREN);
    send_byte(8'h43);
  endtask

  task automatic test_random_records(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + n_items;
    close_value();
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_property();
      end else if (pick < 70) begin
        send_safe(CH_SEMICOLON);
      end else if (pick < 75) begin
        if ($urandom_range(0, 1) == 0) send_safe(CH_RETURN);
        send_safe(CH_NEWLINE);
      end else if (pick < 82) begin
        close_value();
        if (tk_depth < 8'd16) send_safe(CH_LPAREN);
      end else if (pick < 89) begin
        close_value();
        send_safe(CH_RPAREN);
      end else begin
        repeat ($urandom_range(1, 8)) send_safe(CHAR_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_backpressure();
    close_value();
    steady = 1'b1;
    hold_req = 250;
    send_byte(CH_LBRACKET);
    repeat (60) send_byte(CHAR_W'(8'h61 + $urandom_range(0, 25)));
    send_byte(CH_RBRACKET);
    steady = 1'b0;
  endtask

  task automatic test_depth_overflow();
    close_value();
    while (tk_depth < DEPTH_CAP) begin
      send_byte(CH_LPAREN);
      if ($urandom_range(0, 15) == 0) send_byte(letter());
    end
    repeat (3) send_byte(CH_LPAREN);
    send_byte(8'h58);
    send_byte(CH_LBRACKET);
    send_byte(CH_LPAREN);
    send_byte(CH_RPAREN);
    send_byte(CH_RBRACKET);
    send_byte(CH_LPAREN);
    while (tk_depth > 8'd1) begin
      send_byte(CH_RPAREN);
      if ($urandom_range(0, 15) == 0) send_byte(letter());
    end
  endtask

  task automatic test_game_end();
    close_value();
    while (tk_depth > 8'd1) send_byte(CH_RPAREN);
    send_byte(CH_RPAREN);
    send_byte(CH_LPAREN);
    send_byte(8'h42);
    repeat (30) send_byte(CHAR_W'($urandom_range(0, 255)));
  endtask

  initial begin : receiver
    int unsigned n;
    int unsigned mode;
    int unsigned mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((cycle_count % 4) != 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_word
    token_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected word: out_kind %0d out_char %0d out_depth %0d",
               out_kind, out_char, out_depth);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind expected %0d actual %0d", want.kind, out_kind);
          mismatches++;
        end
        if (out_char !== want.ch) begin
          $error("out_char expected %0d actual %0d", want.ch, out_char);
          mismatches++;
        end
        if (out_depth !== want.depth) begin
          $error("out_depth expected %0d actual %0d", want.depth, out_depth);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_preamble();
    test_directed();
    sender_pause();
    wait_drained();
    test_random_records(1100);
    sender_pause();
    wait_drained();
    test_backpressure();
    test_depth_overflow();
    sender_pause();
    wait_drained();
    test_game_end();
    sender_pause();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
